### hdl/ecm_pkg.sv
// shared types, constants and color tables of the energy colormap pixel block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ecm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int CFG_W       = 16;
   localparam int CSR_IDX_W   = 2;

   // index path: diff = sample - floor, idx = trunc(diff / 20)
   localparam int DIFF_W  = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 1;
   localparam int MAG_W   = DIFF_W;
   localparam int IDX_DIV = 20;
   localparam int IDX_K   = DIFF_W + 6;
   localparam int RCP_W   = IDX_K - 4;
   localparam logic [RCP_W-1:0] IDX_RCP = RCP_W'((64'd1 << IDX_K) / 64'd20);
   localparam int Q_W     = MAG_W - 4;
   localparam int IDX_W   = Q_W + 1;
   localparam int PIX_W   = 12;

   // table length path: trunc((ceiling - floor) / 100) * 5 + 1
   localparam int CM_W    = CFG_W + 1;
   localparam int CM_DIV  = 100;
   localparam int CM_K    = 24;
   localparam int CM_RW   = 18;
   localparam logic [CM_RW-1:0] CM_RCP = CM_RW'((64'd1 << CM_K) / 64'd100);
   localparam int CM_Q_W  = 10;
   localparam int IMAX_W  = 14;

   // segment and interpolation widths
   localparam int BP_W      = 20;
   localparam int V2_STEP   = 40;
   localparam int NUM_SEG   = 4;
   localparam int SEG_W     = 2;
   localparam int BPI_W     = 3;
   localparam int OFF_W     = 19;
   localparam int DVD_W     = 28;
   localparam int DVS_W     = OFF_W + 1;
   localparam int QUO_W     = 7;
   localparam int NUM_CHAN  = 3;
   localparam int CH_RED    = 0;
   localparam int CH_GREEN  = 1;
   localparam int CH_BLUE   = 2;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FLOOR   = 2'd0,
      REG_CEILING = 2'd1,
      REG_STOP    = 2'd2,
      REG_SHAPE   = 2'd3
   } ecm_reg_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] energy_floor;
      logic signed [CFG_W-1:0] energy_ceiling;
      logic signed [CFG_W-1:0] stop_level;
      logic signed [CFG_W-1:0] shape_level;
   } ecm_cfg_type;

   typedef logic [NUM_CHAN-1:0][7:0]       ecm_rgb_type;
   typedef logic [NUM_CHAN-1:0][QUO_W-1:0] ecm_span_type;

   // one classified pixel handed from front to back
   typedef struct packed {
      logic                              oor;
      logic                              hit;
      logic [SEG_W-1:0]                  seg;
      logic [NUM_CHAN-1:0][DVD_W-1:0]    dvd;
      logic [DVS_W-1:0]                  dvs;
   } ecm_job_type;

   // divider pipeline stage contents
   typedef struct packed {
      logic                              oor;
      logic                              hit;
      logic [SEG_W-1:0]                  seg;
      logic [NUM_CHAN-1:0][DVD_W-1:0]    rem;
      logic [DVS_W-1:0]                  dvs;
      logic [NUM_CHAN-1:0][QUO_W-1:0]    quo;
   } ecm_div_type;

   // segment start colors, packed {blue, green, red}
   function automatic ecm_rgb_type seg_base(input logic [SEG_W-1:0] seg);
      ecm_rgb_type r;
      case (seg)
         2'd0:    r = {8'd0,  8'd0, 8'd0};
         2'd1:    r = {8'd32, 8'd0, 8'd0};
         2'd2:    r = {8'd80, 8'd0, 8'd48};
         2'd3:    r = {8'd96, 8'd0, 8'd160};
         default: r = '0;
      endcase
      return r;
   endfunction

   // end minus start of each channel, packed {blue, green, red}
   function automatic ecm_span_type seg_span(input logic [SEG_W-1:0] seg);
      ecm_span_type r;
      case (seg)
         2'd0:    r = {7'd32, 7'd0, 7'd0};
         2'd1:    r = {7'd32, 7'd0, 7'd0};
         2'd2:    r = {7'd12, 7'd0, 7'd92};
         2'd3:    r = {7'd96, 7'd0, 7'd95};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### hdl/energy_colormap_pixel.sv
// Maps one signed energy sample per transaction to an RGB pixel through a
// four-segment piecewise linear colormap, black with a flag when the table
// index is out of range. One pixel is accepted every clock cycle while the queue has
// room, and pixels stream out at the same rate unless the output stalls, through four
// front stages for index, range check and segment search, one queue slot, seven
// divider stages that each resolve one quotient bit, and one output register. The
// four-entry queue lets the front keep accepting while the output stalls briefly.
// The user must write registers only while no pixel is in flight; the block does
// not enforce it. Depends on ecm_pkg, ecm_front, ecm_fifo and ecm_back.
`timescale 1ns / 1ps

module energy_colormap_pixel (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ecm_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [7:0]                             rsp_red,
   output logic [7:0]                             rsp_green,
   output logic [7:0]                             rsp_blue,
   output logic                                   rsp_out_of_range,
   input  logic                                   csr_wr_en,
   input  logic [ecm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ecm_pkg::CFG_W-1:0]              csr_wdata
);
   import ecm_pkg::*;

   ecm_cfg_type  cfg_ff;
   logic         fifo_full, push, pop, head_valid;
   ecm_job_type  push_job, head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_floor   <= CFG_W'(0);
         cfg_ff.energy_ceiling <= CFG_W'(10000);
         cfg_ff.stop_level     <= CFG_W'(2000);
         cfg_ff.shape_level    <= CFG_W'(2600);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FLOOR:   cfg_ff.energy_floor   <= csr_wdata;
            REG_CEILING: cfg_ff.energy_ceiling <= csr_wdata;
            REG_STOP:    cfg_ff.stop_level     <= csr_wdata;
            REG_SHAPE:   cfg_ff.shape_level    <= csr_wdata;
            default:     cfg_ff <= cfg_ff;
         endcase
      end
   end

   ecm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .cfg        (cfg_ff),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_job   (push_job)
   );

   ecm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ecm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

### hdl/ecm_front.sv
// front end: accepts samples, computes table index, range check and segment,
// and builds the division job per pixel; depends on ecm_pkg
`timescale 1ns / 1ps

module ecm_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ecm_pkg::SAMPLE_BITS-1:0] req_sample,
   input  ecm_pkg::ecm_cfg_type                   cfg,
   input  logic                                   fifo_full,
   output logic                                   push,
   output ecm_pkg::ecm_job_type                   push_job
);
   import ecm_pkg::*;

   logic front_adv;

   // config derived values
   logic signed [CM_W-1:0]     cm_dc;
   logic                       cm_neg_in, cm_neg_ff;
   logic [CM_W-1:0]            cm_mag_in, cm_mag_ff;
   logic [CM_W+CM_RW-1:0]      cm_prod;
   logic [CM_Q_W-1:0]          cm_q0_in, cm_q0_ff;
   logic [CM_W-1:0]            cm_rem;
   logic [CM_Q_W-1:0]          cm_q;
   logic signed [IMAX_W-1:0]   cm_q5;
   logic signed [IMAX_W-1:0]   imax_in, imax_ff;
   logic signed [BP_W-1:0]     fl20, ce20, st20, sh20;
   logic signed [BP_W-1:0]     bp1_in, bp2_in, bp3_in, bp4_in;
   logic signed [BP_W-1:0]     bp1_ff, bp2_ff, bp3_ff, bp4_ff;

   // stage registers
   logic                       f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;
   logic signed [DIFF_W-1:0]   f1_diff_in, f1_diff_ff;
   logic                       f2_neg_in, f2_neg_ff;
   logic [MAG_W-1:0]           f2_mag_in, f2_mag_ff;
   logic [MAG_W+RCP_W-1:0]     f2_prod;
   logic [Q_W-1:0]             f2_q0_in, f2_q0_ff;
   logic [MAG_W-1:0]           f3_rem;
   logic [Q_W-1:0]             f3_q;
   logic signed [IDX_W-1:0]    f3_idx;
   logic                       f3_oor_in, f3_oor_ff;
   logic [PIX_W-1:0]           f3_idx_ff;
   logic signed [BP_W-1:0]     bp_arr [0:NUM_SEG];
   logic signed [BP_W-1:0]     v2;
   logic [BPI_W-1:0]           lo_idx;
   logic signed [BP_W:0]       den_full, off_full;
   logic                       f4_hit_in, f4_hit_ff, f4_oor_ff;
   logic [SEG_W-1:0]           f4_seg_in, f4_seg_ff;
   logic [OFF_W-1:0]           f4_off_ff, f4_den_ff;
   ecm_span_type               span;

   assign front_adv = !f4_valid_ff || !fifo_full;
   assign req_stall = !front_adv;
   assign push      = f4_valid_ff && !fifo_full;

   // table length and breakpoints, refreshed every cycle
   always_comb begin
      cm_dc     = CM_W'(cfg.energy_ceiling) - CM_W'(cfg.energy_floor);
      cm_neg_in = cm_dc[CM_W-1];
      cm_mag_in = cm_neg_in ? CM_W'(-cm_dc) : CM_W'(cm_dc);
      cm_prod   = (CM_W+CM_RW)'(cm_mag_in) * (CM_W+CM_RW)'(CM_RCP);
      cm_q0_in  = cm_prod[CM_K +: CM_Q_W];
      cm_rem    = cm_mag_ff - CM_W'(cm_q0_ff) * CM_W'(CM_DIV);
      cm_q      = (cm_rem >= CM_W'(CM_DIV)) ? cm_q0_ff + CM_Q_W'(1) : cm_q0_ff;
      cm_q5     = $signed(IMAX_W'(cm_q) * IMAX_W'(5));
      imax_in   = cm_neg_ff ? IMAX_W'(1) - cm_q5 : cm_q5 + IMAX_W'(1);
      fl20      = BP_W'(cfg.energy_floor);
      ce20      = BP_W'(cfg.energy_ceiling);
      st20      = BP_W'(cfg.stop_level);
      sh20      = BP_W'(cfg.shape_level);
      bp1_in    = -fl20;
      bp2_in    = (st20 - fl20) <<< 1;
      bp3_in    = (sh20 - fl20) <<< 1;
      bp4_in    = (ce20 + BP_W'(100) - fl20) <<< 1;
   end

   always_ff @(posedge clock) begin
      cm_neg_ff <= cm_neg_in;
      cm_mag_ff <= cm_mag_in;
      cm_q0_ff  <= cm_q0_in;
      imax_ff   <= imax_in;
      bp1_ff    <= bp1_in;
      bp2_ff    <= bp2_in;
      bp3_ff    <= bp3_in;
      bp4_ff    <= bp4_in;
   end

   // index by reciprocal multiply with one correction step
   always_comb begin
      f1_diff_in = DIFF_W'(req_sample) - DIFF_W'(cfg.energy_floor);
      f2_neg_in  = f1_diff_ff[DIFF_W-1];
      f2_mag_in  = f2_neg_in ? MAG_W'(-f1_diff_ff) : MAG_W'(f1_diff_ff);
      f2_prod    = (MAG_W+RCP_W)'(f2_mag_in) * (MAG_W+RCP_W)'(IDX_RCP);
      f2_q0_in   = f2_prod[IDX_K +: Q_W];
      f3_rem     = f2_mag_ff - MAG_W'(f2_q0_ff) * MAG_W'(IDX_DIV);
      f3_q       = (f3_rem >= MAG_W'(IDX_DIV)) ? f2_q0_ff + Q_W'(1) : f2_q0_ff;
      f3_idx     = f2_neg_ff ? -$signed({1'b0, f3_q}) : $signed({1'b0, f3_q});
      f3_oor_in  = f3_idx[IDX_W-1] || (f3_idx >= IDX_W'(imax_ff));
   end

   // segment search, first matching segment wins
   always_comb begin
      bp_arr[0] = '0;
      bp_arr[1] = bp1_ff;
      bp_arr[2] = bp2_ff;
      bp_arr[3] = bp3_ff;
      bp_arr[4] = bp4_ff;
      v2        = $signed(BP_W'(f3_idx_ff) * BP_W'(V2_STEP));
      f4_hit_in = 1'b0;
      f4_seg_in = '0;
      for (int i = NUM_SEG - 1; i >= 0; i--) begin
         if (v2 >= bp_arr[i] && v2 < bp_arr[i+1]) begin
            f4_hit_in = 1'b1;
            f4_seg_in = SEG_W'(i);
         end
      end
      lo_idx   = BPI_W'(f4_seg_in);
      den_full = (BP_W+1)'(bp_arr[lo_idx + BPI_W'(1)]) - (BP_W+1)'(bp_arr[lo_idx]);
      off_full = (BP_W+1)'(v2) - (BP_W+1)'(bp_arr[lo_idx]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         f1_diff_ff <= f1_diff_in;
         f2_neg_ff  <= f2_neg_in;
         f2_mag_ff  <= f2_mag_in;
         f2_q0_ff   <= f2_q0_in;
         f3_oor_ff  <= f3_oor_in;
         f3_idx_ff  <= PIX_W'(f3_idx);
         f4_oor_ff  <= f3_oor_ff;
         f4_hit_ff  <= f4_hit_in;
         f4_seg_ff  <= f4_seg_in;
         f4_off_ff  <= off_full[OFF_W-1:0];
         f4_den_ff  <= den_full[OFF_W-1:0];
      end
   end

   // dividend 2*span*off + den over divisor 2*den rounds half up
   always_comb begin
      span         = seg_span(f4_seg_ff);
      push_job.oor = f4_oor_ff;
      push_job.hit = f4_hit_ff;
      push_job.seg = f4_seg_ff;
      push_job.dvs = {f4_den_ff, 1'b0};
      for (int c = 0; c < NUM_CHAN; c++) begin
         push_job.dvd[c] = ((DVD_W'(span[c]) * DVD_W'(f4_off_ff)) << 1)
                           + DVD_W'(f4_den_ff);
      end
   end

endmodule

### hdl/ecm_fifo.sv
// short transaction queue between front and back ends
// depends on ecm_pkg
`timescale 1ns / 1ps

module ecm_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ecm_pkg::ecm_job_type  push_job,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ecm_pkg::ecm_job_type  head_job
);
   import ecm_pkg::*;

   ecm_job_type          slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]     count_ff;

   assign full       = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (FIFO_AW+1)'(1);
            2'b01:   count_ff <= count_ff - (FIFO_AW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### hdl/ecm_back.sv
// back end: pipelined restoring divider, one quotient bit per stage,
// then color assembly into the output register; depends on ecm_pkg
`timescale 1ns / 1ps

module ecm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ecm_pkg::ecm_job_type  head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_red,
   output logic [7:0]            rsp_green,
   output logic [7:0]            rsp_blue,
   output logic                  rsp_out_of_range
);
   import ecm_pkg::*;

   function automatic ecm_div_type div_step(input ecm_div_type d, input int b);
      ecm_div_type       r;
      logic [DVD_W-1:0]  trial;
      r     = d;
      trial = DVD_W'(d.dvs) << b;
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (d.rem[c] >= trial) begin
            r.rem[c]    = d.rem[c] - trial;
            r.quo[c][b] = 1'b1;
         end
      end
      return r;
   endfunction

   logic          back_adv;
   logic          st_valid_ff [QUO_W];
   ecm_div_type   st_ff       [QUO_W];
   ecm_div_type   st_in       [QUO_W];
   ecm_div_type   first;
   ecm_rgb_type   base;
   ecm_rgb_type   pix_in;
   logic          rsp_valid_ff;
   ecm_rgb_type   pix_ff;
   logic          oor_ff;

   assign back_adv = !rsp_valid_ff || !rsp_stall;
   assign pop      = back_adv && head_valid;

   always_comb begin
      first.oor = head_job.oor;
      first.hit = head_job.hit;
      first.seg = head_job.seg;
      first.rem = head_job.dvd;
      first.dvs = head_job.dvs;
      first.quo = '0;
      st_in[0]  = div_step(first, QUO_W - 1);
      for (int k = 1; k < QUO_W; k++) begin
         st_in[k] = div_step(st_ff[k-1], QUO_W - 1 - k);
      end
   end

   // black when out of range or in no segment
   always_comb begin
      base = seg_base(st_ff[QUO_W-1].seg);
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (st_ff[QUO_W-1].oor || !st_ff[QUO_W-1].hit) begin
            pix_in[c] = 8'd0;
         end else begin
            pix_in[c] = base[c] + 8'(st_ff[QUO_W-1].quo[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) st_valid_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (back_adv) begin
         st_valid_ff[0] <= head_valid;
         for (int k = 1; k < QUO_W; k++) st_valid_ff[k] <= st_valid_ff[k-1];
         rsp_valid_ff <= st_valid_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (back_adv) begin
         for (int k = 0; k < QUO_W; k++) st_ff[k] <= st_in[k];
         pix_ff <= pix_in;
         oor_ff <= st_ff[QUO_W-1].oor;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = pix_ff[CH_RED];
   assign rsp_green        = pix_ff[CH_GREEN];
   assign rsp_blue         = pix_ff[CH_BLUE];
   assign rsp_out_of_range = oor_ff;

endmodule
